### hdl/dcm_pkg.sv
// Shared constants, payload types and divider control types for the driving cost network.
package dcm_pkg;

  localparam int HIDDEN_UNITS  = 8;
  localparam int FEATURE_COUNT = 10;
  localparam int WEIGHT_COUNT  = FEATURE_COUNT * HIDDEN_UNITS + HIDDEN_UNITS;
  localparam int ADDR_W        = $clog2(WEIGHT_COUNT);
  localparam int FI_W          = $clog2(FEATURE_COUNT + 1);
  localparam int XI_W          = $clog2(FEATURE_COUNT);
  localparam int HU_W          = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

  // Datapath widths
  localparam int X_W   = 18;
  localparam int P_W   = X_W + 16;
  localparam int S_W   = P_W + $clog2(FEATURE_COUNT);
  localparam int O_W   = S_W + 16;
  localparam int ACC_W = 64;

  // Divider widths
  localparam int DIV_R_W = 26;
  localparam int DIV_D_W = 25;
  localparam int DIV_L_W = 16;
  localparam int DIV_Q_W = 17;

  localparam logic [DIV_D_W-1:0] GSQ_DEN     = 25'd30795552;
  localparam logic [13:0]        ACCEL_SCALE = 14'd10000;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] CFG_DESIRED_VELOCITY = 2'd0;
  localparam logic [1:0] CFG_DESIRED_LANE     = 2'd1;
  localparam logic [1:0] CFG_LANE_SPAN        = 2'd2;
  localparam logic [1:0] CFG_EPISODE_LENGTH   = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] speed_now;
    logic signed [15:0] speed_before;
    logic [3:0]         lane_now;
    logic [3:0]         lane_before;
    logic signed [11:0] centre_offset_now;
    logic signed [11:0] centre_offset_before;
    logic [2:0]         event_flags;
    logic [23:0]        lateral_accel_sum;
    logic [6:0]         weight_slot;
    logic signed [15:0] weight_word;
  } dcm_item_t;

  typedef struct packed {
    logic signed [31:0] cost;
  } dcm_result_t;

  typedef struct packed {
    logic               start;
    logic [DIV_R_W-1:0] top;
    logic [DIV_L_W-1:0] low;
    logic [DIV_D_W-1:0] den;
  } dcm_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } dcm_div_rsp_t;

endpackage

### hdl/dcm_if.sv
// Valid/ready channel interfaces for requests and results.
interface dcm_req_if;
  import dcm_pkg::*;
  logic      valid;
  logic      ready;
  dcm_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dcm_res_if;
  import dcm_pkg::*;
  logic        valid;
  logic        ready;
  dcm_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/dcm_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^17.
module dcm_div (
  input  logic                  clk,
  input  logic                  rst,
  input  dcm_pkg::dcm_div_req_t req,
  output dcm_pkg::dcm_div_rsp_t rsp
);
  import dcm_pkg::*;

  localparam int STEP_W = $clog2(DIV_Q_W);

  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  step;
  logic [DIV_R_W-1:0] rem;
  logic [DIV_L_W-1:0] low;
  logic [DIV_D_W-1:0] den;
  logic [DIV_Q_W-1:0] quot;
  logic [DIV_R_W-1:0] trial;
  logic               ge;

  // First step tests the top part directly, later steps shift in the low bits
  always_comb begin
    trial = (step == '0) ? rem : {rem[DIV_R_W-2:0], low[DIV_L_W-1]};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem  <= req.top;
      low  <= req.low;
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? trial - {1'b0, den} : trial;
      if (step != '0) begin
        low <= {low[DIV_L_W-2:0], 1'b0};
      end
      quot <= {quot[DIV_Q_W-2:0], ge};
    end
  end

  assign rsp = '{busy: busy, done: done, quot: quot};

endmodule

### hdl/driving_cost_mlp.sv
// Driving cost network: feature build, weight store and multiply-accumulate sequencer.
//
//   channel | dir | handshake            | payload
//   req     | in  | valid/ready          | dcm_item_t (load weight or evaluate)
//   res     | out | valid/ready          | cost, signed Q8.24
//   cfg     | in  | cfg_we, no back-pressure | cfg_index, cfg_data
//
// A load is written as it is accepted. An evaluate runs from acceptance to result: at most
// thirteen divisions on the shared divider, each an issue, its quotient steps and a done
// strobe, then 88 weight reads from the single memory read port, a drain of the read,
// product, sum and output registers, then done. Saturated terms skip their division.
// Requests are taken only while idle.
// Reset returns the registers to their defaults; the weight store is not cleared.
// A finished cost waits in the output register while the next request is taken.
module driving_cost_mlp (
  input  logic        clk,
  input  logic        rst,
  dcm_req_if.sink     req,
  dcm_res_if.source   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dcm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FT    = 3'd1;
  localparam logic [2:0] S_WT    = 3'd2;
  localparam logic [2:0] S_FL    = 3'd3;
  localparam logic [2:0] S_WL    = 3'd4;
  localparam logic [2:0] S_MAC   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [FI_W-1:0] F_VEL_NOW     = FI_W'(0);
  localparam logic [FI_W-1:0] F_LANE_NOW    = FI_W'(1);
  localparam logic [FI_W-1:0] F_CTR_NOW     = FI_W'(2);
  localparam logic [FI_W-1:0] F_COLLISION   = FI_W'(3);
  localparam logic [FI_W-1:0] F_INV_STATE   = FI_W'(4);
  localparam logic [FI_W-1:0] F_INV_ACTION  = FI_W'(5);
  localparam logic [FI_W-1:0] F_ACCEL       = FI_W'(6);
  localparam logic [FI_W-1:0] F_VEL_BEFORE  = FI_W'(7);
  localparam logic [FI_W-1:0] F_LANE_BEFORE = FI_W'(8);
  localparam logic [FI_W-1:0] F_CTR_BEFORE  = FI_W'(9);

  localparam logic signed [X_W-1:0] ONE_Q16 = 18'sd65536;

  // Configuration registers
  logic signed [15:0] desired_velocity;
  logic [3:0]         desired_lane;
  logic [10:0]        lane_span;
  logic [9:0]         episode_length;

  logic [2:0]         state;
  logic [FI_W-1:0]    fi;
  dcm_item_t          item;
  logic signed [X_W-1:0] tval;
  logic signed [X_W-1:0] x [FEATURE_COUNT];

  logic               accept;
  logic               mem_we;
  logic [ADDR_W-1:0]  raddr;
  logic signed [15:0] wmem [WEIGHT_COUNT];
  logic signed [15:0] rdata;

  dcm_div_req_t       div_req;
  dcm_div_rsp_t       div_rsp;

  // Feature terms
  logic signed [15:0] speed;
  logic signed [16:0] vdiff;
  logic [16:0]        vabs;
  logic [16:0]        vden;
  logic [20:0]        vnum;
  logic signed [11:0] offset;
  logic [11:0]        cabs;
  logic [3:0]         lane;
  logic signed [4:0]  ldiff;
  logic [37:0]        num;
  logic [DIV_D_W-1:0] den;
  logic               clamp_f;
  logic               len_f;
  logic               sat;
  logic signed [X_W-1:0] direct;
  logic [16:0]        tabs;
  logic [9:0]         len_eff;

  // Multiply-accumulate pipeline
  logic [HU_W-1:0]    mh;
  logic [FI_W-1:0]    mf;
  logic               issue_last;
  logic               rd_v;
  logic               rd_out;
  logic [XI_W-1:0]    rd_f;
  logic               pv;
  logic               plast;
  logic signed [P_W-1:0]   prod;
  logic signed [S_W-1:0]   s_acc;
  logic signed [S_W-1:0]   s_sum;
  logic               hv;
  logic signed [S_W-1:0]   hsum;
  logic signed [15:0] vreg;
  logic               ov;
  logic signed [O_W-1:0]   oprod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;
  logic signed [31:0] cost_sat;
  logic               res_valid;
  logic signed [31:0] cost;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign mem_we    = accept && (req.payload.opcode == OP_LOAD) &&
                     (int'(req.payload.weight_slot) < WEIGHT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      desired_velocity <= 16'sd7680;
      desired_lane     <= 4'd0;
      lane_span        <= 11'd896;
      episode_length   <= 10'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DESIRED_VELOCITY: desired_velocity <= cfg_data;
        CFG_DESIRED_LANE:     desired_lane     <= cfg_data[3:0];
        CFG_LANE_SPAN:        lane_span        <= cfg_data[10:0];
        CFG_EPISODE_LENGTH:   episode_length   <= cfg_data[9:0];
        default:              ;
      endcase
    end
  end

  // Feature selection for the current feature index
  always_comb begin
    speed   = (fi == F_VEL_BEFORE) ? item.speed_before : item.speed_now;
    vdiff   = 17'(desired_velocity) - 17'(speed);
    vabs    = vdiff[16] ? 17'(-vdiff) : 17'(vdiff);
    vden    = desired_velocity[15] ? 17'(-17'(desired_velocity)) : 17'(desired_velocity);
    vnum    = 21'(vabs) * 21'd10;
    offset  = (fi == F_CTR_BEFORE) ? item.centre_offset_before : item.centre_offset_now;
    cabs    = offset[11] ? 12'(-offset) : 12'(offset);
    lane    = (fi == F_LANE_BEFORE) ? item.lane_before : item.lane_now;
    ldiff   = 5'(lane) - 5'(desired_lane);
    num     = '0;
    den     = '0;
    clamp_f = 1'b0;
    len_f   = 1'b1;
    direct  = '0;
    case (fi)
      F_VEL_NOW, F_VEL_BEFORE: begin
        num     = 38'(vnum);
        den     = DIV_D_W'(vden);
        clamp_f = 1'b1;
      end
      F_CTR_NOW, F_CTR_BEFORE: begin
        num     = 38'({cabs, 2'b00});
        den     = DIV_D_W'(lane_span);
        clamp_f = 1'b1;
      end
      F_ACCEL: begin
        num     = 38'(item.lateral_accel_sum) * 38'(ACCEL_SCALE);
        den     = GSQ_DEN;
        clamp_f = 1'b1;
      end
      F_LANE_NOW, F_LANE_BEFORE: begin
        if (ldiff == 5'sd0) begin
          direct = ONE_Q16;
        end else if (ldiff == 5'sd1 || ldiff == -5'sd1) begin
          direct = '0;
        end else begin
          direct = -ONE_Q16;
        end
      end
      F_COLLISION: begin
        direct = item.event_flags[0] ? ONE_Q16 : '0;
        len_f  = 1'b0;
      end
      F_INV_STATE: begin
        direct = item.event_flags[1] ? ONE_Q16 : '0;
        len_f  = 1'b0;
      end
      F_INV_ACTION: begin
        direct = item.event_flags[2] ? ONE_Q16 : '0;
      end
      default: ;
    endcase
    sat     = (den == '0) || (num >= 38'({den, 1'b0}));
    tabs    = tval[X_W-1] ? 17'(-tval) : 17'(tval);
    len_eff = (episode_length == '0) ? 10'd1 : episode_length;
  end

  always_comb begin
    div_req = '0;
    if (state == S_FT) begin
      div_req.start = clamp_f && !sat;
      div_req.top   = num[DIV_R_W-1:0];
      div_req.low   = '0;
      div_req.den   = den;
    end else if (state == S_FL) begin
      div_req.start = 1'b1;
      div_req.top   = DIV_R_W'(tabs[16]);
      div_req.low   = tabs[15:0];
      div_req.den   = DIV_D_W'(len_eff);
    end
  end

  dcm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign issue_last = (mh == HU_W'(HIDDEN_UNITS - 1)) && (mf == FI_W'(FEATURE_COUNT));

  always_comb begin
    if (mf == FI_W'(FEATURE_COUNT)) begin
      raddr = ADDR_W'(FEATURE_COUNT * HIDDEN_UNITS) + ADDR_W'(mh);
    end else begin
      raddr = ADDR_W'(mf) * ADDR_W'(HIDDEN_UNITS) + ADDR_W'(mh);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fi    <= '0;
      mh    <= '0;
      mf    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && req.payload.opcode == OP_EVAL) begin
            state <= S_FT;
            fi    <= '0;
          end
        end
        S_FT: begin
          if (clamp_f) begin
            state <= sat ? S_FL : S_WT;
          end else if (len_f) begin
            state <= S_FL;
          end else if (fi == FI_W'(FEATURE_COUNT - 1)) begin
            state <= S_MAC;
            mh    <= '0;
            mf    <= '0;
          end else begin
            fi <= fi + 1'b1;
          end
        end
        S_WT: begin
          if (div_rsp.done) begin
            state <= S_FL;
          end
        end
        S_FL: begin
          state <= S_WL;
        end
        S_WL: begin
          if (div_rsp.done) begin
            if (fi == FI_W'(FEATURE_COUNT - 1)) begin
              state <= S_MAC;
              mh    <= '0;
              mf    <= '0;
            end else begin
              fi    <= fi + 1'b1;
              state <= S_FT;
            end
          end
        end
        S_MAC: begin
          if (mf == FI_W'(FEATURE_COUNT)) begin
            mf <= '0;
            mh <= mh + 1'b1;
          end else begin
            mf <= mf + 1'b1;
          end
          if (issue_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !pv && !hv && !ov) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request capture and feature values
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req.payload;
    end
    if (state == S_FT) begin
      if (clamp_f) begin
        tval <= -ONE_Q16;
      end else if (len_f) begin
        tval <= direct;
      end else begin
        x[fi[XI_W-1:0]] <= direct;
      end
    end
    if (state == S_WT && div_rsp.done) begin
      tval <= ONE_Q16 - X_W'(div_rsp.quot);
    end
    if (state == S_WL && div_rsp.done) begin
      x[fi[XI_W-1:0]] <= tval[X_W-1] ? -X_W'(div_rsp.quot) : X_W'(div_rsp.quot);
    end
  end

  // Weight store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[ADDR_W'(req.payload.weight_slot)] <= req.payload.weight_word;
    end
    rdata <= wmem[raddr];
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      pv   <= 1'b0;
      hv   <= 1'b0;
      ov   <= 1'b0;
    end else begin
      rd_v <= (state == S_MAC);
      pv   <= rd_v && !rd_out;
      hv   <= pv && plast;
      ov   <= hv;
    end
  end

  assign s_sum = s_acc + S_W'(prod);

  always_ff @(posedge clk) begin
    rd_out <= (mf == FI_W'(FEATURE_COUNT));
    rd_f   <= mf[XI_W-1:0];
    if (rd_v && !rd_out) begin
      prod  <= x[rd_f] * rdata;
      plast <= (rd_f == XI_W'(FEATURE_COUNT - 1));
    end
    // Hold the output weight until its hidden sum is ready
    if (rd_v && rd_out) begin
      vreg <= rdata;
    end
    if (accept) begin
      s_acc <= '0;
      acc   <= '0;
    end else begin
      if (pv) begin
        if (plast) begin
          hsum  <= s_sum[S_W-1] ? '0 : s_sum;
          s_acc <= '0;
        end else begin
          s_acc <= s_sum;
        end
      end
      if (ov) begin
        acc <= acc + ACC_W'(oprod);
      end
    end
    if (hv) begin
      oprod <= hsum * vreg;
    end
  end

  // Floor to Q8.24 and saturate
  always_comb begin
    q = acc >>> 16;
    if (q > 64'sd2147483647) begin
      cost_sat = 32'sh7fffffff;
    end else if (q < -64'sd2147483648) begin
      cost_sat = 32'sh80000000;
    end else begin
      cost_sat = q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || res.ready)) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res.ready)) begin
      cost <= cost_sat;
    end
  end

  assign res.valid        = res_valid;
  assign res.payload.cost = cost;

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_pipe_in_mac: assert property (@(posedge clk) disable iff (rst)
    (rd_v || pv || hv || ov) |-> (state == S_MAC || state == S_DRAIN))
    else $error("accumulate pipeline active outside the MAC phase");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE && !rd_v))
    else $error("weight write during evaluation");

endmodule
